FILE: rtl/core/ufr_pkg.sv
// ufr_pkg: shared types, constants and the byte-wide crc-32 step for the
// frame receiver. No dependencies; used by every module in rtl/core.
package ufr_pkg;

  localparam logic [31:0] CRC_POLY    = 32'hEDB8_8320;
  localparam logic [31:0] CRC_PRESET  = 32'hFFFF_FFFF;
  localparam logic [31:0] MAGIC_RESET = 32'h4450_5553;  // "SUPD", first byte in 7:0
  localparam logic [15:0] MAXLEN_RESET = 16'd1024;

  localparam int unsigned HDR_BYTES   = 10;
  localparam int unsigned MAGIC_BYTES = 4;

  localparam int unsigned ADDR_W = 3;

  // register index, taken from paddr bit 2
  localparam logic REG_MAGIC  = 1'b0;
  localparam logic REG_MAXLEN = 1'b1;

  // frame status codes
  localparam logic [1:0] ST_NEED_MORE   = 2'd0;
  localparam logic [1:0] ST_FRAME_READY = 2'd1;
  localparam logic [1:0] ST_OVERSIZE    = 2'd2;
  localparam logic [1:0] ST_CRC_ERROR   = 2'd3;

  typedef struct packed {
    logic [31:0] magic_word;
    logic [15:0] max_payload_length;
  } ufr_cfg_t;

  typedef struct packed {
    logic [1:0]  frame_status;
    logic [7:0]  frame_version;
    logic [7:0]  frame_command;
    logic [15:0] frame_sequence;
    logic [15:0] frame_length;
    logic [7:0]  payload_byte;
    logic        payload_strobe;
    logic [15:0] payload_position;
    logic        header_info_valid;
    logic        frame_in_progress;
  } ufr_result_t;

  // reflected crc-32, one byte, lsb first
  function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'h0, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

FILE: rtl/core/ufr_regs.sv
// ufr_regs: apb-style configuration registers (magic word, payload limit).
// Depends on ufr_pkg.
module ufr_regs (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [ufr_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  output ufr_pkg::ufr_cfg_t          cfg
);

  logic [31:0] magic_r;
  logic [15:0] maxlen_r;
  logic        wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      magic_r  <= ufr_pkg::MAGIC_RESET;
      maxlen_r <= ufr_pkg::MAXLEN_RESET;
    end else if (wr_en) begin
      unique case (paddr[2])
        ufr_pkg::REG_MAGIC:  magic_r  <= pwdata;
        ufr_pkg::REG_MAXLEN: maxlen_r <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      ufr_pkg::REG_MAGIC:  prdata = magic_r;
      ufr_pkg::REG_MAXLEN: prdata = {16'h0, maxlen_r};
      default:             prdata = 32'h0;
    endcase
  end

  assign cfg.magic_word         = magic_r;
  assign cfg.max_payload_length = maxlen_r;

endmodule

FILE: rtl/core/ufr_parser.sv
// ufr_parser: frame parser state, byte-wide crc update and the result of
// one beat. Depends on ufr_pkg.
module ufr_parser (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   step,
  input  logic [7:0]             data_byte,
  input  ufr_pkg::ufr_cfg_t      cfg,
  output ufr_pkg::ufr_result_t   res
);

  typedef enum logic [1:0] {
    PH_SYNC    = 2'd0,
    PH_HEADER  = 2'd1,
    PH_PAYLOAD = 2'd2,
    PH_TRAILER = 2'd3
  } phase_t;

  phase_t      phase_r,   phase_nxt;
  logic [1:0]  mcnt_r,    mcnt_nxt;
  logic [3:0]  hcnt_r,    hcnt_nxt;
  logic [15:0] pcnt_r,    pcnt_nxt;
  logic [1:0]  tcnt_r,    tcnt_nxt;
  logic [23:0] trl_r,     trl_nxt;
  logic [31:0] crc_r,     crc_nxt;
  logic        info_r,    info_nxt;
  logic [7:0]  ver_r,     ver_nxt;
  logic [7:0]  cmd_r,     cmd_nxt;
  logic [15:0] seq_r,     seq_nxt;
  logic [15:0] len_r,     len_nxt;
  logic [7:0]  stage_r [5];
  logic [7:0]  stage_nxt [5];

  logic [7:0]  magic_sel;
  logic        magic_hit;
  logic        magic_first;
  logic [31:0] crc_in;
  logic [31:0] crc_upd;
  logic [2:0]  stage_idx;
  logic [15:0] hdr_len_new;
  logic [15:0] pcnt_inc;
  logic [1:0]  status;
  logic        strobe;

  assign magic_sel   = cfg.magic_word[{mcnt_r, 3'b000} +: 8];
  assign magic_hit   = (data_byte == magic_sel);
  assign magic_first = (data_byte == cfg.magic_word[7:0]);
  // in sync a fresh match starts from the preset
  assign crc_in      = ((phase_r == PH_SYNC) && ((mcnt_r == 2'd0) || !magic_hit)) ?
                       ufr_pkg::CRC_PRESET : crc_r;
  assign crc_upd     = ufr_pkg::crc32_byte(crc_in, data_byte);
  assign stage_idx   = hcnt_r[2:0] - 3'd4;
  assign hdr_len_new = {data_byte, stage_r[4]};
  assign pcnt_inc    = pcnt_r + 16'd1;

  always_comb begin
    phase_nxt = phase_r;
    mcnt_nxt  = mcnt_r;
    hcnt_nxt  = hcnt_r;
    pcnt_nxt  = pcnt_r;
    tcnt_nxt  = tcnt_r;
    trl_nxt   = trl_r;
    crc_nxt   = crc_r;
    info_nxt  = info_r;
    ver_nxt   = ver_r;
    cmd_nxt   = cmd_r;
    seq_nxt   = seq_r;
    len_nxt   = len_r;
    for (int i = 0; i < 5; i++) begin
      stage_nxt[i] = stage_r[i];
    end
    status = ufr_pkg::ST_NEED_MORE;
    strobe = 1'b0;

    unique case (phase_r)
      PH_SYNC: begin
        if (magic_hit) begin
          if (mcnt_r == 2'd0) info_nxt = 1'b0;
          crc_nxt = crc_upd;
          if (mcnt_r == 2'(ufr_pkg::MAGIC_BYTES - 1)) begin
            phase_nxt = PH_HEADER;
            mcnt_nxt  = 2'd0;
            hcnt_nxt  = 4'(ufr_pkg::MAGIC_BYTES);
          end else begin
            mcnt_nxt = mcnt_r + 2'd1;
          end
        end else if (magic_first) begin
          info_nxt = 1'b0;
          crc_nxt  = crc_upd;
          mcnt_nxt = 2'd1;
        end else begin
          mcnt_nxt = 2'd0;
        end
      end
      PH_HEADER: begin
        if (stage_idx < 3'd5) stage_nxt[stage_idx] = data_byte;
        crc_nxt  = crc_upd;
        hcnt_nxt = hcnt_r + 4'd1;
        if (hcnt_r == 4'(ufr_pkg::HDR_BYTES - 1)) begin
          ver_nxt  = stage_r[0];
          cmd_nxt  = stage_r[1];
          seq_nxt  = {stage_r[3], stage_r[2]};
          len_nxt  = hdr_len_new;
          info_nxt = 1'b1;
          if (hdr_len_new > cfg.max_payload_length) begin
            status    = ufr_pkg::ST_OVERSIZE;
            phase_nxt = PH_SYNC;
            hcnt_nxt  = 4'd0;
            crc_nxt   = ufr_pkg::CRC_PRESET;
          end else begin
            phase_nxt = (hdr_len_new == 16'd0) ? PH_TRAILER : PH_PAYLOAD;
          end
        end
      end
      PH_PAYLOAD: begin
        strobe   = 1'b1;
        crc_nxt  = crc_upd;
        pcnt_nxt = pcnt_inc;
        if (pcnt_inc >= len_r) phase_nxt = PH_TRAILER;
      end
      PH_TRAILER: begin
        if (tcnt_r == 2'd3) begin
          status    = (~crc_r == {data_byte, trl_r}) ? ufr_pkg::ST_FRAME_READY
                                                     : ufr_pkg::ST_CRC_ERROR;
          phase_nxt = PH_SYNC;
          hcnt_nxt  = 4'd0;
          pcnt_nxt  = 16'd0;
          tcnt_nxt  = 2'd0;
          trl_nxt   = 24'h0;
          crc_nxt   = ufr_pkg::CRC_PRESET;
        end else begin
          trl_nxt[{tcnt_r, 3'b000} +: 8] = data_byte;
          tcnt_nxt = tcnt_r + 2'd1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_SYNC;
      mcnt_r  <= 2'd0;
      hcnt_r  <= 4'd0;
      pcnt_r  <= 16'd0;
      tcnt_r  <= 2'd0;
      trl_r   <= 24'h0;
      crc_r   <= ufr_pkg::CRC_PRESET;
      info_r  <= 1'b0;
      ver_r   <= 8'h0;
      cmd_r   <= 8'h0;
      seq_r   <= 16'h0;
      len_r   <= 16'h0;
      for (int i = 0; i < 5; i++) begin
        stage_r[i] <= 8'h0;
      end
    end else if (step) begin
      phase_r <= phase_nxt;
      mcnt_r  <= mcnt_nxt;
      hcnt_r  <= hcnt_nxt;
      pcnt_r  <= pcnt_nxt;
      tcnt_r  <= tcnt_nxt;
      trl_r   <= trl_nxt;
      crc_r   <= crc_nxt;
      info_r  <= info_nxt;
      ver_r   <= ver_nxt;
      cmd_r   <= cmd_nxt;
      seq_r   <= seq_nxt;
      len_r   <= len_nxt;
      for (int i = 0; i < 5; i++) begin
        stage_r[i] <= stage_nxt[i];
      end
    end
  end

  assign res.frame_status      = status;
  assign res.frame_version     = ver_nxt;
  assign res.frame_command     = cmd_nxt;
  assign res.frame_sequence    = seq_nxt;
  assign res.frame_length      = len_nxt;
  assign res.payload_byte      = strobe ? data_byte : 8'h0;
  assign res.payload_strobe    = strobe;
  assign res.payload_position  = strobe ? pcnt_r : 16'h0;
  assign res.header_info_valid = info_nxt;
  assign res.frame_in_progress = (phase_nxt != PH_SYNC);

endmodule

FILE: rtl/core/update_frame_receiver_crc32_unit.sv
// update_frame_receiver_crc32_unit: top level of the byte-serial frame receiver.
// Depends on ufr_pkg, ufr_regs and ufr_parser.
//
//   channel | direction | ports                   | beat
//   in_     | input     | valid/ready, data_byte  | one received byte
//   out_    | output    | valid/ready, 10 fields  | one result per input byte
//   cfg_    | apb slave | psel..pready            | register write or read
//
// one byte per cycle sustained while out_ready is held high; an input beat passes the
// input register, then the parser and crc step into the result register.
// the byte-wide crc-32 step and the header compare set the path length.
// reset is synchronous, active low; all registers but in_data_r and out_r reset.
// a stalled result holds the result register and, behind it, the input register.
module update_frame_receiver_crc32_unit (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [7:0]                 in_data_byte,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [1:0]                 out_frame_status,
  output logic [7:0]                 out_frame_version,
  output logic [7:0]                 out_frame_command,
  output logic [15:0]                out_frame_sequence,
  output logic [15:0]                out_frame_length,
  output logic [7:0]                 out_payload_byte,
  output logic                       out_payload_strobe,
  output logic [15:0]                out_payload_position,
  output logic                       out_header_info_valid,
  output logic                       out_frame_in_progress,
  input  logic                       cfg_psel,
  input  logic                       cfg_penable,
  input  logic                       cfg_pwrite,
  input  logic [ufr_pkg::ADDR_W-1:0] cfg_paddr,
  input  logic [31:0]                cfg_pwdata,
  output logic [31:0]                cfg_prdata,
  output logic                       cfg_pready
);

  ufr_pkg::ufr_cfg_t    cfg;
  ufr_pkg::ufr_result_t res;
  ufr_pkg::ufr_result_t out_r;

  logic       in_vld_r;
  logic [7:0] in_data_r;
  logic       out_vld_r;
  logic       advance;

  // move the held byte into the result register when that slot frees up
  assign advance  = in_vld_r & (~out_vld_r | out_ready);
  assign in_ready = ~in_vld_r | advance;

  ufr_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  ufr_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (advance),
    .data_byte (in_data_r),
    .cfg       (cfg),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        in_vld_r <= 1'b1;
      end else if (advance) begin
        in_vld_r <= 1'b0;
      end
      if (advance) begin
        out_vld_r <= 1'b1;
      end else if (out_ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) in_data_r <= in_data_byte;
    if (advance) out_r <= res;
  end

  assign out_valid             = out_vld_r;
  assign out_frame_status      = out_r.frame_status;
  assign out_frame_version     = out_r.frame_version;
  assign out_frame_command     = out_r.frame_command;
  assign out_frame_sequence    = out_r.frame_sequence;
  assign out_frame_length      = out_r.frame_length;
  assign out_payload_byte      = out_r.payload_byte;
  assign out_payload_strobe    = out_r.payload_strobe;
  assign out_payload_position  = out_r.payload_position;
  assign out_header_info_valid = out_r.header_info_valid;
  assign out_frame_in_progress = out_r.frame_in_progress;

endmodule
